/* hdl/mse_pkg.sv */
package mse_pkg;

    localparam int DATA_BYTES_DEF = 8192;

    localparam logic [31:0] DATA_BASE_RST = 32'h1001_0000;
    localparam logic [31:0] RESET_PC_RST  = 32'h0040_0000;

    // configuration register indexes
    localparam logic [1:0] REG_DATA_BASE  = 2'd0;
    localparam logic [1:0] REG_RESET_PC   = 2'd1;
    localparam logic [1:0] REG_BIG_ENDIAN = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_EXIT      = 3'd2;
    localparam logic [2:0] ST_PRINT_INT = 3'd3;
    localparam logic [2:0] ST_PRINT_STR = 3'd4;
    localparam logic [2:0] ST_FAULT     = 3'd5;
    localparam logic [2:0] ST_HALTED    = 3'd6;
    localparam logic [2:0] ST_PRELOAD   = 3'd7;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2a;

    // syscall service numbers in v0
    localparam logic [31:0] SYS_PRINT_INT = 32'd1;
    localparam logic [31:0] SYS_PRINT_STR = 32'd4;
    localparam logic [31:0] SYS_EXIT      = 32'd10;

    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;
    localparam logic [4:0] REG_RA = 5'd31;

    typedef struct packed {
        logic        operation;
        logic [31:0] instr_word;
        logic [12:0] preload_offset;
        logic [7:0]  preload_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] executed_pc;
        logic [31:0] following_pc;
        logic [31:0] syscall_value;
    } t_out_word;

    // write request into the register file
    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    // data memory access: byte count is 1, 2 or 4
    typedef struct packed {
        logic        en;
        logic        we;
        logic [2:0]  nbytes;
        logic        sext;
        logic [31:0] wdata;
    } t_dm_req;

endpackage

/* hdl/mse_regfile.sv */
module mse_regfile (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [4:0]     i_ra_addr,
    input  logic [4:0]     i_rb_addr,
    input  mse_pkg::t_rf_wr i_wr,
    output logic [31:0]    o_ra_data,
    output logic [31:0]    o_rb_data
);
    import mse_pkg::*;

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;

    // entries never written read as zero; $0 is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // write-first read ports
    always_ff @(posedge i_clk) begin
        if (i_wr.we && i_wr.addr == i_ra_addr) begin
            o_ra_data <= i_wr.data;
        end else begin
            o_ra_data <= r_vld[i_ra_addr] ? r_mem[i_ra_addr] : 32'd0;
        end
        if (i_wr.we && i_wr.addr == i_rb_addr) begin
            o_rb_data <= i_wr.data;
        end else begin
            o_rb_data <= r_vld[i_rb_addr] ? r_mem[i_rb_addr] : 32'd0;
        end
    end

endmodule

/* hdl/mse_dmem.sv */
module mse_dmem #(
    parameter int DATA_BYTES = mse_pkg::DATA_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mse_pkg::t_dm_req              i_req,
    input  logic [$clog2(DATA_BYTES)-1:0] i_off,
    input  logic                          i_big_endian,
    output logic [31:0]                   o_rdata,
    output logic                          o_busy
);
    import mse_pkg::*;

    localparam int ROWS  = DATA_BYTES / 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int OFF_W = ROW_W + 2;

    logic [ROW_W-1:0] r_clr_row;
    logic             r_busy;
    logic [ROW_W-1:0] bank_row [4];
    logic [7:0]       bank_wd  [4];
    logic [3:0]       bank_we;
    logic [7:0]       r_q      [4];
    logic [1:0]       r_off_lo;
    logic [2:0]       r_nb;
    logic             r_sext;
    logic             r_be;

    // clearing pass, one row of four bytes per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;

    always_comb begin
        logic [1:0] k;
        logic [1:0] pos;
        for (int j = 0; j < 4; j++) begin
            k   = 2'(j) - i_off[1:0];
            pos = i_big_endian ? 2'(i_req.nbytes - 3'd1 - {1'b0, k}) : k;
            bank_row[j] = i_off[OFF_W-1:2] + ROW_W'(2'(j) < i_off[1:0]);
            bank_wd[j]  = i_req.wdata[8*pos +: 8];
            bank_we[j]  = i_req.en && i_req.we && ({1'b0, k} < i_req.nbytes);
            if (r_busy) begin
                bank_row[j] = r_clr_row;
                bank_wd[j]  = 8'd0;
                bank_we[j]  = 1'b1;
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [7:0] r_bank [ROWS];
        always_ff @(posedge i_clk) begin
            if (bank_we[j]) begin
                r_bank[bank_row[j]] <= bank_wd[j];
            end
            r_q[j] <= r_bank[bank_row[j]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_lo <= i_off[1:0];
        r_nb     <= i_req.nbytes;
        r_sext   <= i_req.sext;
        r_be     <= i_big_endian;
    end

    // byte lanes back into load order, then sign extension
    always_comb begin
        logic [31:0] v;
        logic [1:0]  pos;
        logic [1:0]  bk;
        v = '0;
        for (int k = 0; k < 4; k++) begin
            bk  = r_off_lo + 2'(k);
            pos = r_be ? 2'(r_nb - 3'd1 - 3'(k)) : 2'(k);
            if (3'(k) < r_nb) begin
                v[8*pos +: 8] = r_q[bk];
            end
        end
        if (r_sext && r_nb == 3'd1) begin
            v = {{24{v[7]}}, v[7:0]};
        end else if (r_sext && r_nb == 3'd2) begin
            v = {{16{v[15]}}, v[15:0]};
        end
        o_rdata = v;
    end

endmodule

/* hdl/mips_subset_execute_unit.sv */
// MIPS32 integer subset execute unit. Each input word either executes one
// instruction (taken to be the word at the internal PC) or preloads one data
// byte; every input word yields exactly one output word with a status, the
// PC of the instruction and the PC for the next fetch. Throughput is one
// word per cycle while the output is not stalled: an accepted word is
// held in the execute stage and its result is registered in the output
// register, while a second stage finishes load data and writes the
// register file behind it (that write is forwarded to the execute stage).
// Register file and data memory are synchronous RAMs; the data memory is
// four byte-wide banks so that an unaligned halfword or word is one access.
// After reset the data memory is swept to zero, during which o_in_ready
// stays low (configuration writes still go through). reset_pc is readable
// and writable but the PC always restarts at the register's reset value.
module mips_subset_execute_unit #(
    parameter int DATA_BYTES = mse_pkg::DATA_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mse_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mse_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mse_pkg::*;

    localparam int OFF_W = $clog2(DATA_BYTES);

    // configuration
    logic [31:0] r_data_base;
    logic [31:0] r_reset_pc;
    logic        r_big_endian;

    // execute stage
    logic        r_s1_vld;
    t_in_word    r_s1_word;
    logic [4:0]  r_s1_ra;
    logic [4:0]  r_s1_rb;
    logic [31:0] r_pc;
    logic        r_halted;

    // writeback stage
    logic        r_s2_we;
    logic [4:0]  r_s2_wa;
    logic [31:0] r_s2_val;
    logic        r_s2_ld;

    t_out_word   r_out;
    logic        r_out_vld;

    logic [4:0]  rd_addr_a;
    logic [4:0]  rd_addr_b;
    logic [31:0] rf_a;
    logic [31:0] rf_b;
    t_rf_wr      rf_wr;
    t_dm_req     dm_req;
    logic [OFF_W-1:0] dm_off;
    logic [31:0] dm_rdata;
    logic        dm_busy;
    logic        s1_adv;
    logic        accept;

    // execute results
    logic [31:0] opa;
    logic [31:0] opb;
    t_out_word   res;
    logic        ex_we;
    logic [4:0]  ex_wa;
    logic [31:0] ex_wv;
    logic        ex_ld;
    logic        ex_halt;
    logic        ex_pc_upd;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base  <= DATA_BASE_RST;
            r_reset_pc   <= RESET_PC_RST;
            r_big_endian <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DATA_BASE:  r_data_base  <= pwdata;
                REG_RESET_PC:   r_reset_pc   <= pwdata;
                REG_BIG_ENDIAN: r_big_endian <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DATA_BASE:  prdata = r_data_base;
            REG_RESET_PC:   prdata = r_reset_pc;
            REG_BIG_ENDIAN: prdata = {31'd0, r_big_endian};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !dm_busy && (!r_s1_vld || s1_adv);
    assign accept     = i_in_valid && o_in_ready;

    // Register read addresses: syscall reads v0/a0 instead of rs/rt. While
    // the execute stage is stalled the same registers are read again so the
    // operands track any writeback that lands meanwhile.
    always_comb begin
        logic sys;
        sys = i_in_word.instr_word[31:26] == OP_SPECIAL &&
              i_in_word.instr_word[5:0] == FN_SYSCALL;
        rd_addr_a = sys ? REG_V0 : i_in_word.instr_word[25:21];
        rd_addr_b = sys ? REG_A0 : i_in_word.instr_word[20:16];
        if (r_s1_vld && !s1_adv) begin
            rd_addr_a = r_s1_ra;
            rd_addr_b = r_s1_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_word <= i_in_word;
            r_s1_ra   <= rd_addr_a;
            r_s1_rb   <= rd_addr_b;
        end
    end

    // ---------------- register file ----------------
    assign rf_wr.we   = r_s2_we;
    assign rf_wr.addr = r_s2_wa;
    assign rf_wr.data = r_s2_ld ? dm_rdata : r_s2_val;

    mse_regfile u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ra_addr (rd_addr_a),
        .i_rb_addr (rd_addr_b),
        .i_wr      (rf_wr),
        .o_ra_data (rf_a),
        .o_rb_data (rf_b)
    );

    // bypass the writeback that is in flight this cycle
    assign opa = (rf_wr.we && rf_wr.addr == r_s1_ra) ? rf_wr.data : rf_a;
    assign opb = (rf_wr.we && rf_wr.addr == r_s1_rb) ? rf_wr.data : rf_b;

    // ---------------- execute ----------------
    always_comb begin
        logic [31:0] w;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] imm;
        logic [31:0] se;
        logic [31:0] pc4;
        logic [31:0] sum;
        logic [31:0] ea;
        logic [31:0] off_full;
        logic        win_ok;

        w   = r_s1_word.instr_word;
        op  = w[31:26];
        rt  = w[20:16];
        rd  = w[15:11];
        sh  = w[10:6];
        fn  = w[5:0];
        imm = {16'd0, w[15:0]};
        se  = {{16{w[15]}}, w[15:0]};
        pc4 = r_pc + 32'd4;
        sum = opa + opb;

        res.status        = ST_DONE;
        res.executed_pc   = r_pc;
        res.following_pc  = pc4;
        res.syscall_value = 32'd0;
        ex_we     = 1'b0;
        ex_wa     = rt;
        ex_wv     = 32'd0;
        ex_ld     = 1'b0;
        ex_halt   = 1'b0;
        ex_pc_upd = 1'b0;

        dm_req.en     = 1'b0;
        dm_req.we     = 1'b0;
        dm_req.nbytes = 3'd4;
        dm_req.sext   = 1'b0;
        dm_req.wdata  = opb;

        // load/store window check
        if (op == OP_LB || op == OP_SB) begin
            dm_req.nbytes = 3'd1;
        end else if (op == OP_LH || op == OP_SH) begin
            dm_req.nbytes = 3'd2;
        end
        ea       = opa + se;
        off_full = ea - r_data_base;
        win_ok   = ({1'b0, off_full} + 33'(dm_req.nbytes)) <= 33'(DATA_BYTES);
        dm_off   = off_full[OFF_W-1:0];

        if (r_s1_word.operation) begin
            // preload: one byte, no PC movement, also while halted
            res.status        = ST_PRELOAD;
            res.following_pc  = r_pc;
            dm_req.en     = 32'(r_s1_word.preload_offset) < 32'(DATA_BYTES);
            dm_req.we     = 1'b1;
            dm_req.nbytes = 3'd1;
            dm_req.wdata  = {24'd0, r_s1_word.preload_byte};
            dm_off        = OFF_W'(r_s1_word.preload_offset);
        end else if (r_halted) begin
            res.status       = ST_HALTED;
            res.following_pc = r_pc;
        end else begin
            ex_pc_upd = 1'b1;
            unique case (op) inside
                OP_SPECIAL: begin
                    ex_wa = rd;
                    unique case (fn)
                        FN_ADD: begin
                            if (((opa ^ sum) & (opb ^ sum)) >> 31 != 32'd0) begin
                                res.status = ST_OVERFLOW;
                                ex_halt    = 1'b1;
                            end else begin
                                ex_we = 1'b1;
                                ex_wv = sum;
                            end
                        end
                        FN_ADDU: begin ex_we = 1'b1; ex_wv = sum;         end
                        FN_SUB:  begin ex_we = 1'b1; ex_wv = opa - opb;   end
                        FN_AND:  begin ex_we = 1'b1; ex_wv = opa & opb;   end
                        FN_OR:   begin ex_we = 1'b1; ex_wv = opa | opb;   end
                        FN_XOR:  begin ex_we = 1'b1; ex_wv = opa ^ opb;   end
                        FN_SLT: begin
                            ex_we = 1'b1;
                            ex_wv = {31'd0, $signed(opa) < $signed(opb)};
                        end
                        FN_SLL:  begin ex_we = 1'b1; ex_wv = opb << sh;   end
                        FN_SRL:  begin ex_we = 1'b1; ex_wv = opb >> sh;   end
                        FN_JR:   res.following_pc = opa;
                        FN_SYSCALL: begin
                            // opa holds v0, opb holds a0
                            if (opa == SYS_PRINT_INT) begin
                                res.status        = ST_PRINT_INT;
                                res.syscall_value = opb;
                            end else if (opa == SYS_PRINT_STR) begin
                                res.status        = ST_PRINT_STR;
                                res.syscall_value = opb;
                            end else if (opa == SYS_EXIT) begin
                                res.status = ST_EXIT;
                                ex_halt    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_J: res.following_pc = {pc4[31:28], w[25:0], 2'b00};
                OP_JAL: begin
                    res.following_pc = {pc4[31:28], w[25:0], 2'b00};
                    ex_we = 1'b1;
                    ex_wa = REG_RA;
                    ex_wv = pc4;
                end
                OP_BEQ: begin
                    if (opa == opb) res.following_pc = pc4 + {se[29:0], 2'b00};
                end
                OP_BNE: begin
                    if (opa != opb) res.following_pc = pc4 + {se[29:0], 2'b00};
                end
                OP_ADDI, OP_ADDIU: begin ex_we = 1'b1; ex_wv = opa + se; end
                OP_SLTI: begin
                    ex_we = 1'b1;
                    ex_wv = {31'd0, $signed(opa) < $signed(se)};
                end
                OP_SLTIU: begin ex_we = 1'b1; ex_wv = {31'd0, opa < se}; end
                OP_ANDI:  begin ex_we = 1'b1; ex_wv = opa & imm;         end
                OP_ORI:   begin ex_we = 1'b1; ex_wv = opa | imm;         end
                OP_XORI:  begin ex_we = 1'b1; ex_wv = opa ^ imm;         end
                OP_LUI:   begin ex_we = 1'b1; ex_wv = {w[15:0], 16'd0};  end
                OP_LB, OP_LH, OP_LW: begin
                    if (win_ok) begin
                        dm_req.en   = 1'b1;
                        dm_req.sext = 1'b1;
                        ex_we       = 1'b1;
                        ex_ld       = 1'b1;
                    end else begin
                        res.status = ST_FAULT;
                    end
                end
                OP_SB, OP_SH, OP_SW: begin
                    if (win_ok) begin
                        dm_req.en = 1'b1;
                        dm_req.we = 1'b1;
                    end else begin
                        res.status = ST_FAULT;
                    end
                end
                default: ;
            endcase
        end

        // memory access only when the stage hands its word on
        dm_req.en = dm_req.en && s1_adv;
    end

    mse_dmem #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dmem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (dm_req),
        .i_off        (dm_off),
        .i_big_endian (r_big_endian),
        .o_rdata      (dm_rdata),
        .o_busy       (dm_busy)
    );

    // PC and halt flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= RESET_PC_RST;
            r_halted <= 1'b0;
        end else if (s1_adv && ex_pc_upd) begin
            r_pc <= res.following_pc;
            if (ex_halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    // writeback stage: $0 writes are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_we <= 1'b0;
        end else begin
            r_s2_we <= s1_adv && ex_we && ex_wa != 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_wa  <= ex_wa;
        r_s2_val <= ex_wv;
        r_s2_ld  <= ex_ld;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

/* hdl/mse_checker.sv */
module mse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mse_pkg::t_out_word o_out_word
);
    import mse_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word dropped or changed while stalled");

    a_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_PRELOAD ||
                        o_out_word.status == ST_HALTED)
        |-> o_out_word.executed_pc == o_out_word.following_pc)
        else $error("preload or halted word moved the PC");

    a_sys_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_PRINT_INT &&
        o_out_word.status != ST_PRINT_STR |-> o_out_word.syscall_value == 32'd0)
        else $error("syscall value outside print status");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_out_word.status == ST_EXIT ||
                                       o_out_word.status == ST_OVERFLOW ||
                                       o_out_word.status == ST_HALTED)
        ##1 o_out_valid && o_out_word.status != ST_PRELOAD
        |-> o_out_word.status == ST_HALTED)
        else $error("execution continued after halt");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (.*);
